@@ rtl/vector_magnitude_difference_glyph_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the magnitude difference glyph
// Shared wrappers around clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef VECTOR_MAGNITUDE_DIFFERENCE_GLYPH_ASSERT_SVH
`define VECTOR_MAGNITUDE_DIFFERENCE_GLYPH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define VMDG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vmdg assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define VMDG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vmdg assertion failed");

`endif

@@ rtl/vmdg_pkg.sv @@
// ----------------------------------------------------------------------------
// vmdg_pkg
// Widths, codes and shared types of the magnitude difference glyph.
// ----------------------------------------------------------------------------
package vmdg_pkg;

  localparam int COORD_W   = 32;  // signed Q16.16 coordinates
  localparam int SCALE_W   = 16;  // unsigned Q8.8 scale
  localparam int SCALE_FRAC = 8;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int SUMSQ_W   = 64;  // sum of three squared components
  localparam int ROOT_W    = 32;  // vector length
  localparam int QUO_W     = 31;  // direction magnitude, up to 2^30
  localparam int FRAC_DIR  = 30;  // Q2.30 directions

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST   = 3'd0,
    MODE_SECOND  = 3'd1,
    MODE_SMALLER = 3'd2,
    MODE_LARGER  = 3'd3,
    MODE_HALF    = 3'd4
  } align_mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

endpackage

@@ rtl/vector_magnitude_difference_glyph.sv @@
// ----------------------------------------------------------------------------
// vector_magnitude_difference_glyph
// Compares two scaled 3-D vectors at a point and emits one line segment.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry a point and two vectors, Q16.16.
//   Each accepted beat yields exactly one output beat (out_valid/out_ready)
//   with the segment start, end and the second_is_larger flag, in order.
//   Configuration beats (cfg_valid/cfg_ready) write scale_factor (index 0)
//   or alignment_mode (index 1); other indexes are dropped. cfg_ready is
//   always high; write only while no beat is in flight.
// Pipeline: two 32-stage square roots and two 31-stage dividers in series
//   plus eleven other stages lie between input beat and output beat.
// Throughput: one beat per cycle. The whole pipeline advances together
//   whenever the output register is empty or taken, so in_ready equals
//   !out_valid || out_ready; a stalled receiver freezes every stage.
// Reset: all valid bits clear, scale_factor returns to 1.0 (256) and
//   alignment_mode to half vector.
// ----------------------------------------------------------------------------
module vector_magnitude_difference_glyph (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_point_y,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_point_z,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_first_vec_x,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_first_vec_y,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_first_vec_z,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_second_vec_x,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_second_vec_y,
  input  logic signed [vmdg_pkg::COORD_W-1:0]   in_second_vec_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vmdg_pkg::COORD_W-1:0]   out_start_x,
  output logic signed [vmdg_pkg::COORD_W-1:0]   out_start_y,
  output logic signed [vmdg_pkg::COORD_W-1:0]   out_start_z,
  output logic signed [vmdg_pkg::COORD_W-1:0]   out_end_x,
  output logic signed [vmdg_pkg::COORD_W-1:0]   out_end_y,
  output logic signed [vmdg_pkg::COORD_W-1:0]   out_end_z,
  output logic                                  out_second_is_larger,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vmdg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vmdg_pkg::SCALE_W-1:0]          cfg_data
);

  localparam int CW      = vmdg_pkg::COORD_W;
  localparam int RW      = vmdg_pkg::ROOT_W;
  localparam int QW      = vmdg_pkg::QUO_W;
  localparam int SQW     = vmdg_pkg::SUMSQ_W;
  localparam int FD      = vmdg_pkg::FRAC_DIR;
  localparam int SF      = vmdg_pkg::SCALE_FRAC;
  localparam int SP_W    = CW + vmdg_pkg::SCALE_W + 1;
  localparam int SQ_W    = SP_W - SF;
  localparam int NUM_W   = RW + QW;
  localparam int PROD_W  = RW + 1 + CW;
  localparam int OFF_W   = CW + 2;
  localparam int SUM_W   = OFF_W + 1;
  localparam int SQ_LAT  = SQW / 2;
  localparam int DIV_LAT = QW;

  localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    vmdg_pkg::vec3_t pt;
    vmdg_pkg::vec3_t a;
    vmdg_pkg::vec3_t b;
  } side1_t;

  typedef struct packed {
    vmdg_pkg::vec3_t pt;
    logic [2:0]      neg_a;
    logic [2:0]      neg_b;
    logic [RW-1:0]   r0;
    logic [RW-1:0]   r1;
  } side2_t;

  typedef struct packed {
    vmdg_pkg::vec3_t pt;
    vmdg_pkg::vec3_t ua;
    vmdg_pkg::vec3_t ub;
    logic [RW-1:0]   r0;
    logic [RW-1:0]   r1;
  } hv_t;

  typedef struct packed {
    hv_t             hv;
    vmdg_pkg::vec3_t sabs;
    logic [2:0]      sneg;
  } side3_t;

  typedef struct packed {
    hv_t        hv;
    logic [2:0] sneg;
    logic       mzero;
  } side4_t;

  // scale one component, round half away from zero, saturate
  function automatic logic [CW-1:0] scale_comp(input logic [CW-1:0] v,
                                               input logic [vmdg_pkg::SCALE_W-1:0] sc);
    logic signed [SP_W-1:0] prod;
    logic [SP_W-1:0]        mag;
    logic [SQ_W-1:0]        q;
    logic [CW-1:0]          res;
    prod = $signed(v) * $signed({1'b0, sc});
    mag  = prod[SP_W-1] ? SP_W'(-prod) : SP_W'(prod);
    q    = SQ_W'((mag + SP_W'(1 << (SF - 1))) >> SF);
    if (!prod[SP_W-1]) begin
      res = (q > SQ_W'(MAX_POS)) ? MAX_POS : q[CW-1:0];
    end else begin
      res = (q > SQ_W'(MIN_NEG)) ? MIN_NEG : CW'(-q);
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] abs_c(input logic [CW-1:0] v);
    return v[CW-1] ? -v : v;
  endfunction

  function automatic logic [CW-1:0] signed_quo(input logic neg, input logic [QW-1:0] q);
    logic [CW-1:0] t;
    t = CW'(q);
    return neg ? -t : t;
  endfunction

  // round a Q2.30 product to integer units, half away from zero
  function automatic logic [OFF_W-1:0] round_dir(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [OFF_W-1:0]  q;
    mag = p[PROD_W-1] ? -p : p;
    q   = OFF_W'((mag + PROD_W'(1 << (FD - 1))) >> FD);
    return p[PROD_W-1] ? -q : q;
  endfunction

  function automatic logic [CW-1:0] place_sat(input logic [CW-1:0] pt,
                                              input logic [OFF_W-1:0] off);
    logic signed [SUM_W-1:0] s;
    logic [CW-1:0]           res;
    s = SUM_W'($signed(pt)) + SUM_W'($signed(off));
    if (s > $signed(SUM_W'(MAX_POS))) begin
      res = MAX_POS;
    end else if (s < -$signed(SUM_W'(MIN_NEG))) begin
      res = MIN_NEG;
    end else begin
      res = s[CW-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [vmdg_pkg::SCALE_W-1:0] scale_r;
  logic [vmdg_pkg::MODE_W-1:0]  mode_r;

  logic adv;

  vmdg_pkg::vec3_t in_pt, in_a, in_b;

  // stage registers
  logic            s1_valid_r;
  side1_t          s1_r, s1_nxt;
  logic            s2_valid_r;
  side1_t          s2_r;
  logic [2:0][SQW-1:0] s2_sqa_r, s2_sqb_r, s2_sqa_nxt, s2_sqb_nxt;
  logic            s3_valid_r;
  side1_t          s3_r;
  logic [SQW-1:0]  s3_suma_r, s3_sumb_r;

  logic [RW-1:0]   r0_root, r1_root;
  logic            q1_valid;
  side1_t          q1_side;
  side2_t          side2;
  logic [2:0][NUM_W-1:0] num_a, num_b;
  logic [2:0][QW-1:0]    quo_a, quo_b;
  logic            q2_valid;
  side2_t          q2_side;

  logic            u_valid_r;
  hv_t             u_r, u_nxt;
  logic            sv_valid_r;
  side3_t          sv_r, sv_nxt;
  logic            sq_valid_r;
  side3_t          sq_r;
  logic [2:0][SQW-1:0] sq_s_r, sq_s_nxt;
  logic            m_valid_r;
  side3_t          m_r;
  logic [SQW-1:0]  m_sum_r;

  logic [RW-1:0]   m_root;
  logic            q3_valid;
  side3_t          q3_side;
  side4_t          side4;
  logic [2:0][NUM_W-1:0] num_h;
  logic [2:0][QW-1:0]    quo_h;
  logic            q4_valid;
  side4_t          q4_side;

  logic            h_valid_r;
  vmdg_pkg::vec3_t h_dir_r, h_dir_nxt, h_pt_r, h_half;
  logic [RW-1:0]   h_lo_r, h_hi_r, h_lo_nxt, h_hi_nxt;
  logic            h_flag_r, h_flag_nxt;

  logic            p_valid_r;
  logic [2:0][PROD_W-1:0] p_lo_r, p_hi_r, p_lo_nxt, p_hi_nxt;
  vmdg_pkg::vec3_t p_pt_r;
  logic            p_flag_r;

  logic            r_valid_r;
  logic [2:0][OFF_W-1:0] r_lo_r, r_hi_r;
  vmdg_pkg::vec3_t r_pt_r;
  logic            r_flag_r;

  logic            out_valid_r;
  vmdg_pkg::vec3_t o_start_r, o_end_r, o_start_nxt, o_end_nxt;
  logic            o_flag_r;

  // hold configuration; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= vmdg_pkg::SCALE_RESET;
      mode_r  <= vmdg_pkg::MODE_HALF;
    end else if (cfg_valid) begin
      if (cfg_index == vmdg_pkg::CFG_SCALE) begin
        scale_r <= cfg_data;
      end else if (cfg_index == vmdg_pkg::CFG_MODE) begin
        mode_r <= cfg_data[vmdg_pkg::MODE_W-1:0];
      end
    end
  end

  assign cfg_ready = 1'b1;

  // whole pipeline advances when the output register can take a beat
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign in_pt = {in_point_z, in_point_y, in_point_x};
  assign in_a  = {in_first_vec_z, in_first_vec_y, in_first_vec_x};
  assign in_b  = {in_second_vec_z, in_second_vec_y, in_second_vec_x};

  // scale both vectors
  always_comb begin
    s1_nxt.pt = in_pt;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.a[i] = scale_comp(in_a[i], scale_r);
      s1_nxt.b[i] = scale_comp(in_b[i], scale_r);
    end
  end

  // square the components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_sqa_nxt[i] = SQW'(abs_c(s1_r.a[i])) * SQW'(abs_c(s1_r.a[i]));
      s2_sqb_nxt[i] = SQW'(abs_c(s1_r.b[i])) * SQW'(abs_c(s1_r.b[i]));
    end
  end

  // lengths of both vectors
  vmdg_sqrt_pipe #(.IN_W(SQW)) u_sqrt_a (
    .clk(clk), .en(adv), .rad(s3_suma_r), .root(r0_root)
  );
  vmdg_sqrt_pipe #(.IN_W(SQW)) u_sqrt_b (
    .clk(clk), .en(adv), .rad(s3_sumb_r), .root(r1_root)
  );
  vmdg_delay #(.WIDTH($bits(side1_t)), .DEPTH(SQ_LAT)) u_dly_len (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(s3_valid_r), .in_data(s3_r),
    .out_valid(q1_valid), .out_data(q1_side)
  );

  // unit directions: |v| * 2^30 plus half the length, over the length
  always_comb begin
    side2.pt = q1_side.pt;
    side2.r0 = r0_root;
    side2.r1 = r1_root;
    for (int i = 0; i < 3; i++) begin
      side2.neg_a[i] = q1_side.a[i][CW-1];
      side2.neg_b[i] = q1_side.b[i][CW-1];
      num_a[i] = NUM_W'({abs_c(q1_side.a[i]), {FD{1'b0}}}) + NUM_W'(r0_root[RW-1:1]);
      num_b[i] = NUM_W'({abs_c(q1_side.b[i]), {FD{1'b0}}}) + NUM_W'(r1_root[RW-1:1]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unit
    vmdg_div_pipe #(.DEN_W(RW), .QUO_W(QW)) u_div_a (
      .clk(clk), .en(adv), .num(num_a[i]), .den(r0_root), .quo(quo_a[i])
    );
    vmdg_div_pipe #(.DEN_W(RW), .QUO_W(QW)) u_div_b (
      .clk(clk), .en(adv), .num(num_b[i]), .den(r1_root), .quo(quo_b[i])
    );
  end

  vmdg_delay #(.WIDTH($bits(side2_t)), .DEPTH(DIV_LAT)) u_dly_unit (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(q1_valid), .in_data(side2),
    .out_valid(q2_valid), .out_data(q2_side)
  );

  // signed directions; a zero vector keeps a zero direction
  always_comb begin
    u_nxt.pt = q2_side.pt;
    u_nxt.r0 = q2_side.r0;
    u_nxt.r1 = q2_side.r1;
    for (int i = 0; i < 3; i++) begin
      u_nxt.ua[i] = (q2_side.r0 == '0) ? '0 : signed_quo(q2_side.neg_a[i], quo_a[i]);
      u_nxt.ub[i] = (q2_side.r1 == '0) ? '0 : signed_quo(q2_side.neg_b[i], quo_b[i]);
    end
  end

  // half vector sum, split into sign and magnitude
  always_comb begin
    logic [CW:0] s;
    s = '0;
    sv_nxt.hv = u_r;
    for (int i = 0; i < 3; i++) begin
      s = {u_r.ua[i][CW-1], u_r.ua[i]} + {u_r.ub[i][CW-1], u_r.ub[i]};
      sv_nxt.sneg[i] = s[CW];
      sv_nxt.sabs[i] = s[CW] ? CW'(-s) : s[CW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_s_nxt[i] = SQW'(sv_r.sabs[i]) * SQW'(sv_r.sabs[i]);
    end
  end

  // length of the half vector
  vmdg_sqrt_pipe #(.IN_W(SQW)) u_sqrt_h (
    .clk(clk), .en(adv), .rad(m_sum_r), .root(m_root)
  );
  vmdg_delay #(.WIDTH($bits(side3_t)), .DEPTH(SQ_LAT)) u_dly_hlen (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(m_valid_r), .in_data(m_r),
    .out_valid(q3_valid), .out_data(q3_side)
  );

  always_comb begin
    side4.hv    = q3_side.hv;
    side4.sneg  = q3_side.sneg;
    side4.mzero = (m_root == '0);
    for (int i = 0; i < 3; i++) begin
      num_h[i] = NUM_W'({q3_side.sabs[i], {FD{1'b0}}}) + NUM_W'(m_root[RW-1:1]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_half
    vmdg_div_pipe #(.DEN_W(RW), .QUO_W(QW)) u_div_h (
      .clk(clk), .en(adv), .num(num_h[i]), .den(m_root), .quo(quo_h[i])
    );
  end

  vmdg_delay #(.WIDTH($bits(side4_t)), .DEPTH(DIV_LAT)) u_dly_half (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_valid(q3_valid), .in_data(side4),
    .out_valid(q4_valid), .out_data(q4_side)
  );

  // pick the direction and the two distances
  always_comb begin
    logic [RW-1:0] r0, r1;
    r0 = q4_side.hv.r0;
    r1 = q4_side.hv.r1;
    for (int i = 0; i < 3; i++) begin
      h_half[i] = q4_side.mzero ? '0 : signed_quo(q4_side.sneg[i], quo_h[i]);
    end
    h_lo_nxt   = (r0 < r1) ? r0 : r1;
    h_hi_nxt   = (r0 > r1) ? r0 : r1;
    h_flag_nxt = !(r0 > r1);
    case (mode_r)
      vmdg_pkg::MODE_FIRST: begin
        h_dir_nxt = q4_side.hv.ua;
      end
      vmdg_pkg::MODE_SECOND: begin
        h_dir_nxt = q4_side.hv.ub;
      end
      vmdg_pkg::MODE_SMALLER: begin
        h_dir_nxt = (r0 > r1) ? q4_side.hv.ub : q4_side.hv.ua;
      end
      vmdg_pkg::MODE_LARGER: begin
        h_dir_nxt = (r1 > r0) ? q4_side.hv.ub : q4_side.hv.ua;
      end
      default: begin
        h_dir_nxt = h_half;
        h_lo_nxt  = r0;
        h_hi_nxt  = r1;
      end
    endcase
  end

  // distance times direction
  always_comb begin
    logic signed [PROD_W-1:0] pl, ph;
    pl = '0;
    ph = '0;
    for (int i = 0; i < 3; i++) begin
      pl = $signed({1'b0, h_lo_r}) * $signed(h_dir_r[i]);
      ph = $signed({1'b0, h_hi_r}) * $signed(h_dir_r[i]);
      p_lo_nxt[i] = pl;
      p_hi_nxt[i] = ph;
    end
  end

  // offset the point and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_start_nxt[i] = place_sat(r_pt_r[i], r_lo_r[i]);
      o_end_nxt[i]   = place_sat(r_pt_r[i], r_hi_r[i]);
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      u_valid_r   <= 1'b0;
      sv_valid_r  <= 1'b0;
      sq_valid_r  <= 1'b0;
      m_valid_r   <= 1'b0;
      h_valid_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      u_valid_r   <= q2_valid;
      sv_valid_r  <= u_valid_r;
      sq_valid_r  <= sv_valid_r;
      m_valid_r   <= sq_valid_r;
      h_valid_r   <= q4_valid;
      p_valid_r   <= h_valid_r;
      r_valid_r   <= p_valid_r;
      out_valid_r <= r_valid_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= s1_nxt;
      s2_r      <= s1_r;
      s2_sqa_r  <= s2_sqa_nxt;
      s2_sqb_r  <= s2_sqb_nxt;
      s3_r      <= s2_r;
      s3_suma_r <= s2_sqa_r[0] + s2_sqa_r[1] + s2_sqa_r[2];
      s3_sumb_r <= s2_sqb_r[0] + s2_sqb_r[1] + s2_sqb_r[2];
      u_r       <= u_nxt;
      sv_r      <= sv_nxt;
      sq_r      <= sv_r;
      sq_s_r    <= sq_s_nxt;
      m_r       <= sq_r;
      m_sum_r   <= sq_s_r[0] + sq_s_r[1] + sq_s_r[2];
      h_dir_r   <= h_dir_nxt;
      h_lo_r    <= h_lo_nxt;
      h_hi_r    <= h_hi_nxt;
      h_pt_r    <= q4_side.hv.pt;
      h_flag_r  <= h_flag_nxt;
      p_lo_r    <= p_lo_nxt;
      p_hi_r    <= p_hi_nxt;
      p_pt_r    <= h_pt_r;
      p_flag_r  <= h_flag_r;
      for (int i = 0; i < 3; i++) begin
        r_lo_r[i] <= round_dir(p_lo_r[i]);
        r_hi_r[i] <= round_dir(p_hi_r[i]);
      end
      r_pt_r    <= p_pt_r;
      r_flag_r  <= p_flag_r;
      o_start_r <= o_start_nxt;
      o_end_r   <= o_end_nxt;
      o_flag_r  <= r_flag_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_start_x          = o_start_r[0];
  assign out_start_y          = o_start_r[1];
  assign out_start_z          = o_start_r[2];
  assign out_end_x            = o_end_r[0];
  assign out_end_y            = o_end_r[1];
  assign out_end_z            = o_end_r[2];
  assign out_second_is_larger = o_flag_r;

endmodule

@@ rtl/vmdg_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// vmdg_sqrt_pipe
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module vmdg_sqrt_pipe #(
  parameter int IN_W = 64
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     rad,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [REM_W-1:0] rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];
  logic [IN_W-1:0]  rad_r  [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  rad_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    // bring down the next two radicand bits and try a one bit
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[OUT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[OUT_W-2:0], 1'b0};
        end
        rad_r[k] <= {rad_in[IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

@@ rtl/vmdg_div_pipe.sv @@
// ----------------------------------------------------------------------------
// vmdg_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The caller keeps
// the quotient below 2^QUO_W; a zero divisor gives a don't-care quotient.
// ----------------------------------------------------------------------------
module vmdg_div_pipe #(
  parameter int DEN_W = 32,
  parameter int QUO_W = 31
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  localparam int NUM_W = DEN_W + QUO_W;

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num[NUM_W-1:QUO_W];
      assign low_in = num[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    // shift in the next dividend bit and subtract when it fits
    assign t    = {rem_in, low_in[QUO_W-1]};
    assign ge   = (t >= {1'b0, den_in});
    assign diff = t - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        low_r[k] <= {low_in[QUO_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[QUO_W-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

@@ rtl/vmdg_delay.sv @@
// ----------------------------------------------------------------------------
// vmdg_delay
// Enabled delay line carrying a valid bit beside its data.
// ----------------------------------------------------------------------------
module vmdg_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic             vld_r  [DEPTH];
  logic [WIDTH-1:0] data_r [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    logic             vld_in;
    logic [WIDTH-1:0] data_in;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign data_in = in_data;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign data_in = data_r[k-1];
    end

    // advance valid; clear it under reset
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    // advance data
    always_ff @(posedge clk) begin
      if (en) begin
        data_r[k] <= data_in;
      end
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = data_r[DEPTH-1];

endmodule

@@ rtl/vmdg_checker.sv @@
// ----------------------------------------------------------------------------
// vmdg_checker
// Port-level checks of the magnitude difference glyph, bound to the top.
// ----------------------------------------------------------------------------
`include "vector_magnitude_difference_glyph_assert.svh"

module vmdg_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [vmdg_pkg::COORD_W-1:0]   out_end_x,
  input logic                           out_second_is_larger
);

  // a stalled result beat stays up, with end_x and the flag held stable
  `VMDG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `VMDG_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_end_x) && $stable(out_second_is_larger))

  // input side flows whenever the output register is free or drained
  `VMDG_ASSERT_IMPLY(a_in_free, clk, rst_n, !out_valid, in_ready)
  `VMDG_ASSERT_IMPLY(a_in_drain, clk, rst_n, out_ready, in_ready)

endmodule

bind vector_magnitude_difference_glyph vmdg_checker u_vmdg_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_end_x(out_end_x),
  .out_second_is_larger(out_second_is_larger)
);

@@ tb/tb_vector_magnitude_difference_glyph.sv @@
// ----------------------------------------------------------------------------
// tb_vector_magnitude_difference_glyph
// Self-checking bench for the magnitude difference glyph. A table of directed
// beats walks the field extremes, every alignment mode and the corner cases.
// Random phases follow, each under its own scale and mode. Every output beat
// is checked in order against a bit-exact fixed-point predictor or a typed-in result.
// ----------------------------------------------------------------------------
module tb_vector_magnitude_difference_glyph;
  timeunit 1ns;
  timeprecision 1ps;

  import vmdg_pkg::*;

  localparam int     DRAIN_CYCLES  = 160;      // pipeline depth plus margin
  localparam int     CYCLE_LIMIT   = 2000000;
  localparam int     RANDOM_PHASES = 10;
  localparam int     PHASE_BEATS   = 123;
  localparam longint ONE_Q30       = longint'(1) << FRAC_DIR;

  typedef struct packed {
    vec3_t point;
    vec3_t first;
    vec3_t second;
  } glyph_in_t;

  typedef struct packed {
    vec3_t start;
    vec3_t stop;
    logic  second_larger;
  } segment_t;

  typedef struct {
    logic [SCALE_W-1:0] scale;
    logic [MODE_W-1:0]  mode;
    glyph_in_t          stim;
    bit                 fixed;
    segment_t           want;
  } table_row_t;

  typedef longint trio_t [3];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [COORD_W-1:0] in_first_vec_x = '0, in_first_vec_y = '0, in_first_vec_z = '0;
  logic signed [COORD_W-1:0] in_second_vec_x = '0, in_second_vec_y = '0;
  logic signed [COORD_W-1:0] in_second_vec_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_start_x, out_start_y, out_start_z;
  logic signed [COORD_W-1:0] out_end_x, out_end_y, out_end_z;
  logic out_second_is_larger;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0]   cfg_data = '0;

  // Predictor copy of the configuration
  logic [SCALE_W-1:0] scale_setting;
  logic [MODE_W-1:0]  mode_setting;

  segment_t   pending_segments[$];
  table_row_t directed_rows[$];
  int         fail_count = 0;
  bit         quiet_phase = 1'b0;
  int         stall_left = 0;

  vector_magnitude_difference_glyph DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_first_vec_x(in_first_vec_x), .in_first_vec_y(in_first_vec_y),
    .in_first_vec_z(in_first_vec_z),
    .in_second_vec_x(in_second_vec_x), .in_second_vec_y(in_second_vec_y),
    .in_second_vec_z(in_second_vec_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_start_x(out_start_x), .out_start_y(out_start_y), .out_start_z(out_start_z),
    .out_end_x(out_end_x), .out_end_y(out_end_y), .out_end_z(out_end_z),
    .out_second_is_larger(out_second_is_larger),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_coord(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Round to nearest, ties away from zero; den is positive
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'h1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] vec_length(trio_t a);
    logic [63:0] acc;
    logic [63:0] mag;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      mag = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
      acc = acc + mag * mag;
    end
    return int_sqrt(acc);
  endfunction

  function automatic trio_t unit_dir(trio_t a, logic [63:0] len);
    trio_t u;
    for (int i = 0; i < 3; i++)
      u[i] = (len == 0) ? 0 : round_div(a[i] * ONE_Q30, longint'(len));
    return u;
  endfunction

  function automatic logic [COORD_W-1:0] place_point(longint p, logic [63:0] r, longint d);
    return COORD_W'(sat_coord(p + round_div(longint'(r) * d, ONE_Q30)));
  endfunction

  function automatic segment_t predict_segment(glyph_in_t g);
    trio_t pt, a, b, ua, ub, sel, half;
    logic [63:0] r0, r1, rmin, rmax, rs, re;
    segment_t seg;
    for (int i = 0; i < 3; i++) begin
      pt[i] = longint'($signed(g.point[i]));
      a[i] = sat_coord(round_div(longint'($signed(g.first[i])) * longint'(scale_setting), 256));
      b[i] = sat_coord(round_div(longint'($signed(g.second[i])) * longint'(scale_setting), 256));
    end
    r0 = vec_length(a);
    r1 = vec_length(b);
    ua = unit_dir(a, r0);
    ub = unit_dir(b, r1);
    rmin = (r0 < r1) ? r0 : r1;
    rmax = (r0 > r1) ? r0 : r1;
    // Pick the line direction and the two distances along it
    case (mode_setting)
      MODE_FIRST:   sel = ua;
      MODE_SECOND:  sel = ub;
      MODE_SMALLER: sel = (r0 > r1) ? ub : ua;
      MODE_LARGER:  sel = (r1 > r0) ? ub : ua;
      default: begin
        for (int i = 0; i < 3; i++) half[i] = ua[i] + ub[i];
        sel = unit_dir(half, vec_length(half));
      end
    endcase
    if (mode_setting <= MODE_LARGER) begin
      rs = rmin;
      re = rmax;
    end else begin
      rs = r0;
      re = r1;
    end
    for (int i = 0; i < 3; i++) begin
      seg.start[i] = place_point(pt[i], rs, sel[i]);
      seg.stop[i] = place_point(pt[i], re, sel[i]);
    end
    seg.second_larger = (r0 > r1) ? 1'b0 : 1'b1;
    return seg;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic vec3_t v3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      4, 5, 6: return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
      7:       return 32'h7FFFFFFF;
      8:       return 32'h80000000;
      9:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic glyph_in_t rand_glyph();
    glyph_in_t g;
    for (int i = 0; i < 3; i++) begin
      g.point[i] = rand_coord();
      g.first[i] = rand_coord();
      g.second[i] = rand_coord();
    end
    // Bias some beats toward opposite and equal-length vector pairs
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 3; i++) g.second[i] = -g.first[i];
      1: g.second = v3(g.first[1], g.first[2], g.first[0]);
      2: g.second = g.first;
      default: ;
    endcase
    return g;
  endfunction

  task automatic add_row(logic [SCALE_W-1:0] scale, logic [MODE_W-1:0] mode,
                         vec3_t pt, vec3_t a, vec3_t b, bit fixed, segment_t want);
    table_row_t row;
    row.scale = scale;
    row.mode = mode;
    row.stim = '{point: pt, first: a, second: b};
    row.fixed = fixed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Write one register; configure writes back to back and drops the strobe after the last beat
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SCALE) scale_setting = data;
    else if (idx == CFG_MODE) mode_setting = data[MODE_W-1:0];
  endtask

  task automatic configure(logic [SCALE_W-1:0] scale, logic [MODE_W-1:0] mode);
    cfg_write(CFG_SCALE, scale);
    cfg_write(CFG_MODE, SCALE_W'(mode));
    cfg_write(2'd2 + CFG_IDX_W'($urandom_range(0, 1)), SCALE_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Hold until every segment is back and the pipeline has emptied
  task automatic drain();
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_beat(glyph_in_t g, bit fixed, segment_t want);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = (quiet_phase || pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= g.point[0];
    in_point_y <= g.point[1];
    in_point_z <= g.point[2];
    in_first_vec_x <= g.first[0];
    in_first_vec_y <= g.first[1];
    in_first_vec_z <= g.first[2];
    in_second_vec_x <= g.second[0];
    in_second_vec_y <= g.second[1];
    in_second_vec_z <= g.second[2];
    do @(posedge clk); while (!in_ready);
    pending_segments.push_back(fixed ? want : predict_segment(g));
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    segment_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        $error("output beat with no segment expected");
        fail_count++;
      end else begin
        want = pending_segments.pop_front();
        check_field("start_x", want.start[0], out_start_x);
        check_field("start_y", want.start[1], out_start_y);
        check_field("start_z", want.start[2], out_start_z);
        check_field("end_x", want.stop[0], out_end_x);
        check_field("end_y", want.stop[1], out_end_y);
        check_field("end_z", want.stop[2], out_end_z);
        check_field("second_is_larger", 32'(want.second_larger), 32'(out_second_is_larger));
      end
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet_phase && pick < 20) begin
      stall_left <= (pick < 2) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    segment_t none;
    segment_t zero_seg;
    vec3_t pt;
    logic [SCALE_W-1:0] scale_picks [RANDOM_PHASES];
    none = '0;
    zero_seg = '{start: '0, stop: '0, second_larger: 1'b1};
    scale_setting = SCALE_RESET;
    mode_setting = MODE_HALF;

    // Directed table: zero input, zero vectors and opposite vectors are typed in
    add_row(256, MODE_HALF, '0, '0, '0, 1'b1, zero_seg);
    pt = v3(32'h7FFFFFFF, 32'h80000000, 32'h0);
    add_row(256, MODE_HALF, pt, '0, '0, 1'b1, '{start: pt, stop: pt, second_larger: 1'b1});
    pt = v3(100, 200, 300);
    add_row(256, MODE_HALF, pt, v3(32'h10000, 0, 0), v3(-32'sh10000, 0, 0), 1'b1,
            '{start: pt, stop: pt, second_larger: 1'b1});
    add_row(256, MODE_HALF, '0, v3(32'h10000, 0, 0), v3(0, 32'h10000, 0), 1'b0, none);
    add_row(256, MODE_HALF, v3(5, -7, 9), v3(32'h30000, 32'h1234, -32'sh5000),
            v3(32'h800, 32'h900, 32'h100), 1'b0, none);
    add_row(256, MODE_HALF, v3(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
            v3(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
            v3(32'h80000000, 32'h80000000, 32'h80000000), 1'b0, none);
    add_row(65535, MODE_HALF, v3(32'h80000000, 0, 32'h7FFFFFFF),
            v3(32'h7FFFFFFF, 1, -1), v3(-32'sh123456, 32'h80000000, 32'h40000), 1'b0, none);
    add_row(256, MODE_FIRST, v3(1, 2, 3), v3(32'h20000, 32'h10000, 0),
            v3(0, 32'h50000, 32'h30000), 1'b0, none);
    add_row(256, MODE_SECOND, v3(1, 2, 3), v3(32'h20000, 32'h10000, 0),
            v3(0, 32'h50000, 32'h30000), 1'b0, none);
    add_row(256, MODE_SMALLER, '0, v3(32'h10000, 0, 0), v3(0, 0, -32'sh10000), 1'b0, none);
    add_row(256, MODE_LARGER, '0, v3(32'h10000, 0, 0), v3(0, 0, -32'sh10000), 1'b0, none);
    add_row(256, MODE_SMALLER, v3(-9, 4, 0), v3(32'h90000, 32'h1000, 0),
            v3(32'h1000, -32'sh2000, 32'h3000), 1'b0, none);
    add_row(256, MODE_LARGER, v3(-9, 4, 0), v3(32'h90000, 32'h1000, 0),
            v3(32'h1000, -32'sh2000, 32'h3000), 1'b0, none);
    add_row(256, 3'd5, v3(7, 7, 7), v3(32'h30000, 0, 32'h10000), v3(0, 32'h20000, 0), 1'b0, none);
    add_row(256, 3'd6, v3(7, 7, 7), v3(32'h30000, 0, 32'h10000), v3(0, 32'h20000, 0), 1'b0, none);
    pt = v3(-3, 11, 32'h80000000);
    add_row(256, 3'd7, pt, v3(32'h4000, -32'sh8000, 32'h2000),
            v3(-32'sh4000, 32'h8000, -32'sh2000), 1'b1,
            '{start: pt, stop: pt, second_larger: 1'b1});
    pt = v3(32'h12345678, -32'sh1000, 32'h7FFFFFFF);
    add_row(0, MODE_FIRST, pt, v3(32'h7FFFFFFF, 32'h80000000, 32'h55555555),
            v3(32'h80000000, 32'h1, 32'hAAAAAAAA), 1'b1,
            '{start: pt, stop: pt, second_larger: 1'b1});
    add_row(65535, MODE_LARGER, v3(32'h7FFFFFFF, 32'h7FFFFFF0, 0),
            v3(32'h7FFFFFFF, 32'h7FFFFFFF, 0), v3(32'h100, 0, 0), 1'b0, none);
    add_row(1, MODE_SECOND, v3(0, 0, 1), v3(32'h100, 32'h80, 0),
            v3(32'h7FFFFFFF, 32'h200, 32'h80000000), 1'b0, none);
    add_row(256, MODE_FIRST, v3(32'h80000000, 32'h80000000, 32'h80000000),
            v3(32'h80000000, 32'h80000000, 32'h80000000), v3(1, 1, 1), 1'b0, none);

    // Hold reset, then release it and start on a clock edge
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; reconfigure only after the pipeline has emptied
    foreach (directed_rows[k]) begin
      if (directed_rows[k].scale != scale_setting || directed_rows[k].mode != mode_setting) begin
        in_valid <= 1'b0;
        drain();
        configure(directed_rows[k].scale, directed_rows[k].mode);
      end
      send_beat(directed_rows[k].stim, directed_rows[k].fixed, directed_rows[k].want);
    end

    // Random phases, each under its own scale and mode
    scale_picks = '{256, 0, 65535, 1, 128, 512, 16'($urandom), 16'($urandom), 256, 16'($urandom)};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_valid <= 1'b0;
      drain();
      quiet_phase = (p % 4 == 3);
      configure(scale_picks[p], (p < 8) ? MODE_W'(p) : MODE_W'($urandom_range(0, 7)));
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(rand_glyph(), 1'b0, none);
    end
    in_valid <= 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
